// ----- rtl/core/weekly_alarm_due_finder_core_assert.svh -----
// Assertion macros for the due finder checker.
`ifndef WEEKLY_ALARM_DUE_FINDER_CORE_ASSERT_SVH
`define WEEKLY_ALARM_DUE_FINDER_CORE_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define WADF_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("wadf: assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define WADF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wadf: assertion failed");

`endif

// ----- rtl/core/wadf_pkg.sv -----
package wadf_pkg;

  localparam int unsigned MinPerDay  = 1440;
  localparam int unsigned WeekDays   = 7;
  localparam int unsigned BackDays   = WeekDays;
  localparam int unsigned AheadDays  = WeekDays + 1;
  // floor(x / 45) == (x * RecipMul) >> RecipShift for any 26-bit x
  localparam logic [26:0] RecipMul   = 27'd95443718;
  localparam int unsigned RecipShift = 32;

  localparam int unsigned NowW  = 31;
  localparam int unsigned DowW  = 3;
  localparam int unsigned QuotW = 21;
  localparam int unsigned TodW  = 11;
  localparam int unsigned RemW  = 11;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned OffW  = 14;

  typedef enum logic [1:0] {
    CFG_HOUR   = 2'd0,
    CFG_MINUTE = 2'd1,
    CFG_DAYS   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [NowW-1:0] now;
    logic [DowW-1:0] dow;
  } req_t;

  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic [NowW-1:0]  now;
    logic [DowW-1:0]  dow;
  } quot_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [KeyW-1:0] base;
    logic [DowW-1:0] dow;
  } day_t;

  typedef struct packed {
    logic            next_found;
    logic [KeyW-1:0] next_due;
    logic            prev_found;
    logic [KeyW-1:0] prev_due;
  } res_t;

  typedef struct packed {
    logic [TodW-1:0] tod;
    logic [6:0]      days;
  } alarm_t;

  // d * 1440 as shifts and adds
  function automatic logic [OffW-1:0] day_minutes(input logic [3:0] d);
    logic [OffW-1:0] dx;
    dx = OffW'(d);
    return (dx << 10) + (dx << 8) + (dx << 7) + (dx << 5);
  endfunction

  function automatic logic [2:0] mod7(input logic [4:0] v);
    logic [4:0] w;
    w = v;
    if (w >= 5'd14) begin
      w = w - 5'd14;
    end else if (w >= 5'd7) begin
      w = w - 5'd7;
    end
    return w[2:0];
  endfunction

endpackage

// ----- rtl/core/wadf_recip_mul.sv -----
module wadf_recip_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  wadf_pkg::req_t    up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output wadf_pkg::quot_t   dn_data
);

  logic                 valid_r;
  wadf_pkg::quot_t      data_r;
  wadf_pkg::quot_t      data_nxt;
  logic [25:0]          x;
  logic [52:0]          prod;

  // now / 1440 == (now >> 5) / 45
  assign x    = up_data.now[wadf_pkg::NowW-1:5];
  assign prod = {27'b0, x} * {26'b0, wadf_pkg::RecipMul};

  always_comb begin
    data_nxt.quot = prod[wadf_pkg::RecipShift +: wadf_pkg::QuotW];
    data_nxt.now  = up_data.now;
    data_nxt.dow  = up_data.dow;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/core/wadf_day_base.sv -----
module wadf_day_base (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [wadf_pkg::TodW-1:0]   tod,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  wadf_pkg::quot_t             up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output wadf_pkg::day_t              dn_data
);

  logic                          valid_r;
  wadf_pkg::day_t                data_r;
  wadf_pkg::day_t                data_nxt;
  logic [wadf_pkg::NowW-1:0]     today;
  logic [wadf_pkg::NowW-1:0]     q;
  logic [wadf_pkg::NowW-1:0]     diff;

  assign q     = wadf_pkg::NowW'(up_data.quot);
  assign today = (q << 10) + (q << 8) + (q << 7) + (q << 5);
  assign diff  = up_data.now - today;

  always_comb begin
    data_nxt.rem  = diff[wadf_pkg::RemW-1:0];
    data_nxt.base = wadf_pkg::KeyW'(today) + wadf_pkg::KeyW'(tod);
    data_nxt.dow  = up_data.dow;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/core/wadf_pick.sv -----
module wadf_pick (
  input  logic               clk,
  input  logic               rst_n,
  input  wadf_pkg::alarm_t   alarm,
  input  logic               up_valid,
  output logic               up_ready,
  input  wadf_pkg::day_t     up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output wadf_pkg::res_t     dn_data
);

  logic                            valid_r;
  wadf_pkg::res_t                  data_r;
  wadf_pkg::res_t                  data_nxt;
  logic                            one_shot;
  logic [wadf_pkg::OffW-1:0]       tod_w;
  logic [wadf_pkg::OffW-1:0]       rem_w;
  logic [wadf_pkg::BackDays-1:0]   hit_b;
  logic [wadf_pkg::AheadDays-1:0]  hit_f;
  logic [2:0]                      sel_b;
  logic [3:0]                      sel_f;
  logic [2:0]                      wd;

  assign one_shot = (alarm.days == '0);
  assign tod_w    = wadf_pkg::OffW'(alarm.tod);
  assign rem_w    = wadf_pkg::OffW'(up_data.rem);

  always_comb begin
    hit_b = '0;
    hit_f = '0;
    wd    = '0;
    for (int d = 0; d < wadf_pkg::BackDays; d++) begin
      wd = wadf_pkg::mod7(5'(up_data.dow) + 5'd6 - 5'(d));
      hit_b[d] = (tod_w <= rem_w + wadf_pkg::day_minutes(4'(d))) &&
                 (one_shot ? (d == 0) : alarm.days[wd]);
    end
    for (int d = 0; d < wadf_pkg::AheadDays; d++) begin
      wd = wadf_pkg::mod7(5'(up_data.dow) + 5'd6 + 5'(d));
      hit_f[d] = (tod_w + wadf_pkg::day_minutes(4'(d)) > rem_w) &&
                 (one_shot ? (d < 2) : alarm.days[wd]);
    end
  end

  // nearest day wins
  always_comb begin
    sel_b = '0;
    sel_f = '0;
    for (int d = wadf_pkg::BackDays - 1; d >= 0; d--) begin
      if (hit_b[d]) begin
        sel_b = 3'(d);
      end
    end
    for (int d = wadf_pkg::AheadDays - 1; d >= 0; d--) begin
      if (hit_f[d]) begin
        sel_f = 4'(d);
      end
    end
  end

  always_comb begin
    data_nxt.prev_found = |hit_b;
    data_nxt.next_found = |hit_f;
    data_nxt.prev_due   = (|hit_b) ?
        up_data.base - wadf_pkg::KeyW'(wadf_pkg::day_minutes({1'b0, sel_b})) : '0;
    data_nxt.next_due   = (|hit_f) ?
        up_data.base + wadf_pkg::KeyW'(wadf_pkg::day_minutes(sel_f)) : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- rtl/core/weekly_alarm_due_finder_core.sv -----
// Weekly alarm due finder. Each request carries the current minute key and
// weekday; the result gives the latest alarm instant at or before now and the
// earliest one strictly after it, each with a found flag. One request is taken
// per cycle while the output is not stalled and passes the input register,
// reciprocal multiply for the day split, day base and candidate pick into the
// output register. A stalled output holds a stage only once the next is full.
// The user must write configuration registers through the cfg port only while
// no request is in flight, unenforced by the block; cfg_ready is always high.
module weekly_alarm_due_finder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [30:0] now_minute, [33:31] now_day_of_week
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [0] prev_found, [32:1] prev_due,
                                  // [33] next_found, [65:34] next_due
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [4:0]                  hour_r;
  logic [5:0]                  minute_r;
  logic [6:0]                  days_r;
  logic [wadf_pkg::TodW-1:0]   tod;
  wadf_pkg::alarm_t            alarm;

  logic                        in_valid_r;
  wadf_pkg::req_t              in_data_r;
  logic                        q_valid;
  logic                        q_ready;
  wadf_pkg::quot_t             q_data;
  logic                        m_ready;
  logic                        b_valid;
  logic                        b_ready;
  wadf_pkg::day_t              b_data;
  wadf_pkg::res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= '0;
      minute_r <= '0;
      days_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wadf_pkg::CFG_HOUR:   hour_r   <= cfg_data[4:0];
        wadf_pkg::CFG_MINUTE: minute_r <= cfg_data[5:0];
        wadf_pkg::CFG_DAYS:   days_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tod = (wadf_pkg::TodW'(hour_r) << 6) - (wadf_pkg::TodW'(hour_r) << 2) +
               wadf_pkg::TodW'(minute_r);

  always_comb begin
    alarm.tod  = tod;
    alarm.days = days_r;
  end

  assign in_tready = !in_valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r.now <= in_tdata[30:0];
      in_data_r.dow <= in_tdata[33:31];
    end
  end

  wadf_recip_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .up_ready (m_ready),
    .up_data  (in_data_r),
    .dn_valid (q_valid),
    .dn_ready (q_ready),
    .dn_data  (q_data)
  );

  wadf_day_base u_base (
    .clk      (clk),
    .rst_n    (rst_n),
    .tod      (tod),
    .up_valid (q_valid),
    .up_ready (q_ready),
    .up_data  (q_data),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_data  (b_data)
  );

  wadf_pick u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .alarm    (alarm),
    .up_valid (b_valid),
    .up_ready (b_ready),
    .up_data  (b_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  assign out_tdata = {6'b0, res.next_due, res.next_found, res.prev_due, res.prev_found};

endmodule

// ----- rtl/core/wadf_checker.sv -----
`include "weekly_alarm_due_finder_core_assert.svh"

module wadf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  logic        prev_found;
  logic [31:0] prev_due;
  logic        next_found;
  logic [31:0] next_due;

  assign prev_found = out_tdata[0];
  assign prev_due   = out_tdata[32:1];
  assign next_found = out_tdata[33];
  assign next_due   = out_tdata[65:34];

  // a later instant always exists within the forward window
  `WADF_ASSERT_NOW(a_next_always, !out_tvalid || next_found)
  `WADF_ASSERT_NOW(a_prev_zero, !out_tvalid || prev_found || (prev_due == 32'd0))
  `WADF_ASSERT_NOW(a_order, !out_tvalid || !prev_found ||
      ($signed({1'b0, next_due}) > $signed({prev_due[31], prev_due})))
  `WADF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
      out_tvalid && $stable(out_tdata))
  // input only stalls behind a stalled result
  `WADF_ASSERT_NOW(a_in_ready, in_tready || (out_tvalid && !out_tready))

endmodule

bind weekly_alarm_due_finder_core wadf_checker u_wadf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
